/* rtl/udf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udf_pkg
// Shared constants and types of the feedback deframer: frame markers, the
// byte window cell link and the decoded result record.
// ----------------------------------------------------------------------------
package udf_pkg;

  // frame geometry and markers
  localparam int unsigned WinLen   = 16;
  localparam logic [7:0]  HeadMark = 8'hAA;
  localparam logic [7:0]  TailMark = 8'h55;
  localparam logic [3:0]  NibMask  = 4'hF;

  // one window slot as it moves from cell to cell
  typedef struct packed {
    logic [7:0] data;
    logic       live;
  } slot_t;

  // one decoded feedback frame
  typedef struct packed {
    logic [31:0] frame_id;
    logic [63:0] payload;
    logic [3:0]  fault_code;
    logic [3:0]  node_low;
    logic [15:0] position_code;
    logic [11:0] velocity_code;
    logic [11:0] torque_code;
    logic [7:0]  driver_temp;
    logic [7:0]  winding_temp;
    logic [31:0] frame_count;
  } result_t;

endpackage

/* rtl/udf_intf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udf_rx_if / udf_fb_if
// Valid/ready channels of the deframer: incoming serial bytes and outgoing
// decoded feedback frames.
// ----------------------------------------------------------------------------
interface udf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface udf_fb_if;
  logic        valid;
  logic        ready;
  logic [31:0] frame_id;
  logic [63:0] payload;
  logic [3:0]  fault_code;
  logic [3:0]  node_low;
  logic [15:0] position_code;
  logic [11:0] velocity_code;
  logic [11:0] torque_code;
  logic [7:0]  driver_temp;
  logic [7:0]  winding_temp;
  logic [31:0] frame_count;

  modport source (
    output valid, input ready,
    output frame_id, output payload, output fault_code, output node_low,
    output position_code, output velocity_code, output torque_code,
    output driver_temp, output winding_temp, output frame_count
  );
  modport sink (
    input valid, output ready,
    input frame_id, input payload, input fault_code, input node_low,
    input position_code, input velocity_code, input torque_code,
    input driver_temp, input winding_temp, input frame_count
  );
endinterface

/* rtl/usb_can_feedback_deframer_top.sv */
`timescale 1ns / 1ps
// A decoded frame is pushed into the registered result queue as its tail byte is taken.
// Throughput: one byte per cycle while input ready is high; the row of sixteen
// window cells shifts and runs its header search on every accepted byte.
// Input ready drops only while two decoded frames wait on the output.
// Reset clears the live flags, the frame count and the result queue; no
// clearing pass, the block takes bytes from the first cycle after reset.
// ----------------------------------------------------------------------------
// usb_can_feedback_deframer_top
// Finds 16-byte frames framed by 0xAA and 0x55 in a byte stream and unpacks
// the CAN id and motor feedback fields of each good frame.
// ----------------------------------------------------------------------------
module usb_can_feedback_deframer_top import udf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  udf_rx_if.sink   rx_i,
  udf_fb_if.source fb_o
);

  slot_t       link_w [WinLen];   // slot arriving at each cell
  slot_t       cur_w  [WinLen];   // slot held by each cell
  logic        seen_w [WinLen+1];
  logic        head_w [WinLen];
  logic [7:0]  b      [WinLen];   // window bytes after this move

  logic        accept, full, emit, q_full;
  logic [31:0] count_q, count_d;
  result_t     res;

  assign rx_i.ready = !q_full;
  assign accept     = rx_i.valid && rx_i.ready;

  // window is full when the slot moving into the front is live
  assign full = link_w[0].live;
  assign emit = full && head_w[0] && (rx_i.rx_byte == TailMark);

  assign seen_w[0] = 1'b0;

  // row of window cells, newest byte enters at the top
  for (genvar g = 0; g < WinLen; g++) begin : g_win
    if (g == WinLen - 1) begin : g_top
      assign link_w[g] = '{data: rx_i.rx_byte, live: 1'b1};
    end else begin : g_mid
      assign link_w[g] = cur_w[g+1];
    end
    assign b[g] = link_w[g].data;

    udf_cell u_slot (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept),
      .full_i  (full),
      .emit_i  (emit),
      .front_i (g == 0),
      .slot_i  (link_w[g]),
      .seen_i  (seen_w[g]),
      .seen_o  (seen_w[g+1]),
      .head_o  (head_w[g]),
      .slot_o  (cur_w[g])
    );
  end

  // good frame counter
  assign count_d = count_q + 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 32'd0;
    end else if (accept && emit) begin
      count_q <= count_d;
    end
  end

  // unpack the frame, payload byte 0 sits at frame byte 7
  always_comb begin
    res.frame_id      = {b[6], b[5], b[4], b[3]};
    res.payload       = {b[7], b[8], b[9], b[10], b[11], b[12], b[13], b[14]};
    res.fault_code    = b[7][7:4] & NibMask;
    res.node_low      = b[7][3:0] & NibMask;
    res.position_code = {b[8], b[9]};
    res.velocity_code = {b[10], b[11][7:4]};
    res.torque_code   = {b[11][3:0], b[12]};
    res.driver_temp   = b[13];
    res.winding_temp  = b[14];
    res.frame_count   = count_d;
  end

  // result queue
  udf_out_q u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept && emit),
    .item_i (res),
    .full_o (q_full),
    .fb_o   (fb_o)
  );

endmodule

/* rtl/udf_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udf_cell
// One window slot. Takes the slot of its upper neighbour on every accepted
// byte, flags a header byte and extends the header-seen chain; when the
// window is full it keeps its slot only if a header lies at or below it.
// ----------------------------------------------------------------------------
module udf_cell import udf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,   // byte accepted, move the row down by one
  input  logic  full_i,    // window holds sixteen bytes after this move
  input  logic  emit_i,    // good frame found, empty the window
  input  logic  front_i,   // oldest slot, always dropped on a full window
  input  slot_t slot_i,    // slot arriving from the upper neighbour
  input  logic  seen_i,    // header seen in some lower slot
  output logic  seen_o,
  output logic  head_o,    // arriving byte is a header
  output slot_t slot_o
);

  logic [7:0] data_q;
  logic       live_q, live_d;
  logic       keep;

  // header detection and prefix chain
  assign head_o = (slot_i.data == HeadMark);
  assign seen_o = seen_i | head_o;
  assign keep   = !front_i && !emit_i && seen_o;

  // next live bit
  always_comb begin
    live_d = live_q;
    if (shift_i) begin
      live_d = full_i ? keep : slot_i.live;
    end
  end

  // live flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else begin
      live_q <= live_d;
    end
  end

  // byte store
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= slot_i.data;
    end
  end

  assign slot_o = '{data: data_q, live: live_q};

endmodule

/* rtl/udf_out_q.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udf_out_q
// Two-entry result queue: an output register plus a skid entry, so that a
// waiting result does not hold up the byte stream.
// ----------------------------------------------------------------------------
module udf_out_q import udf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t item_i,
  output logic    full_o,
  udf_fb_if.source fb_o
);

  result_t main_q, main_d, skid_q, skid_d;
  logic    main_v_q, main_v_d, skid_v_q, skid_v_d;
  logic    pop;

  assign pop    = main_v_q && fb_o.ready;
  assign full_o = skid_v_q;

  // queue update, push only arrives while the skid entry is free
  always_comb begin
    main_d   = main_q;
    skid_d   = skid_q;
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    if (pop) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        skid_d   = item_i;
        skid_v_d = push_i;
      end else begin
        main_d   = item_i;
        main_v_d = push_i;
      end
    end else if (push_i) begin
      if (main_v_q) begin
        skid_d   = item_i;
        skid_v_d = 1'b1;
      end else begin
        main_d   = item_i;
        main_v_d = 1'b1;
      end
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  // entry payloads
  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  // drive the result channel
  assign fb_o.valid         = main_v_q;
  assign fb_o.frame_id      = main_q.frame_id;
  assign fb_o.payload       = main_q.payload;
  assign fb_o.fault_code    = main_q.fault_code;
  assign fb_o.node_low      = main_q.node_low;
  assign fb_o.position_code = main_q.position_code;
  assign fb_o.velocity_code = main_q.velocity_code;
  assign fb_o.torque_code   = main_q.torque_code;
  assign fb_o.driver_temp   = main_q.driver_temp;
  assign fb_o.winding_temp  = main_q.winding_temp;
  assign fb_o.frame_count   = main_q.frame_count;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds the feedback deframer a byte stream of good, broken and truncated
// frames mixed with line noise. A local copy of the byte window predicts
// every decoded frame, and each frame leaving the block is checked field by
// field. Both channels stall at random, with one stretch free of stalls.
// ----------------------------------------------------------------------------
module testbench;
  import udf_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned QuietFrom   = 600;
  localparam int unsigned QuietTo     = 1100;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomBytes = 1050;

  logic clk_i = 1'b0;
  logic rst_ni;

  udf_rx_if rx_ch ();
  udf_fb_if fb_ch ();

  usb_can_feedback_deframer_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_ch),
    .fb_o   (fb_ch)
  );

  always #5 clk_i = ~clk_i;

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // bytes still to be sent, and frames the block still owes us
  logic [7:0] pending_bytes[$];
  result_t    expected_feedback[$];

  // local copy of the byte window and the good frame count
  logic [7:0]  win_bytes [WinLen];
  int unsigned win_fill    = 0;
  logic [31:0] good_frames = '0;

  // add one byte to the end of the send queue
  function automatic void append_byte(logic [7:0] v);
    pending_bytes = {pending_bytes, v};
  endfunction

  // the roll comes up idle with a chance of about one in ten, except inside the quiet stretch
  function automatic bit stall_roll();
    return (cycle_count < QuietFrom || cycle_count >= QuietTo) &&
           ($urandom_range(0, 99) < 10);
  endfunction

  // discard the k oldest buffered bytes
  function automatic void drop_oldest(int unsigned k);
    for (int i = 0; i < WinLen; i++) begin
      win_bytes[i] = (i + k < WinLen) ? win_bytes[i + k] : 8'h00;
    end
    win_fill = (k >= win_fill) ? 0 : win_fill - k;
  endfunction

  // append one received byte and work out whether it completes a frame
  function automatic void predict_rx_byte(logic [7:0] b);
    int unsigned head_at;
    result_t     fb;
    win_bytes[win_fill] = b;
    win_fill++;
    if (win_fill < WinLen) return;
    head_at = WinLen;
    for (int i = WinLen - 1; i >= 0; i--) begin
      if (win_bytes[i] == HeadMark) head_at = i;
    end
    if (head_at == WinLen) begin
      drop_oldest(WinLen);
    end else if (head_at != 0) begin
      drop_oldest(head_at);
    end else if (win_bytes[WinLen - 1] != TailMark) begin
      drop_oldest(1);
    end else begin
      good_frames      = good_frames + 32'd1;
      fb.frame_id      = {win_bytes[6], win_bytes[5], win_bytes[4], win_bytes[3]};
      fb.payload       = {win_bytes[7], win_bytes[8], win_bytes[9], win_bytes[10],
                          win_bytes[11], win_bytes[12], win_bytes[13], win_bytes[14]};
      fb.fault_code    = win_bytes[7][7:4];
      fb.node_low      = win_bytes[7][3:0];
      fb.position_code = {win_bytes[8], win_bytes[9]};
      fb.velocity_code = {win_bytes[10], win_bytes[11][7:4]};
      fb.torque_code   = {win_bytes[11][3:0], win_bytes[12]};
      fb.driver_temp   = win_bytes[13];
      fb.winding_temp  = win_bytes[14];
      fb.frame_count   = good_frames;
      expected_feedback = {expected_feedback, fb};
      drop_oldest(WinLen);
    end
  endfunction

  function automatic void check_feedback(result_t want, result_t got);
    if (got.frame_id !== want.frame_id) begin
      $error("frame_id: expected %h, got %h", want.frame_id, got.frame_id);
      error_count++;
    end
    if (got.payload !== want.payload) begin
      $error("payload: expected %h, got %h", want.payload, got.payload);
      error_count++;
    end
    if (got.fault_code !== want.fault_code) begin
      $error("fault_code: expected %h, got %h", want.fault_code, got.fault_code);
      error_count++;
    end
    if (got.node_low !== want.node_low) begin
      $error("node_low: expected %h, got %h", want.node_low, got.node_low);
      error_count++;
    end
    if (got.position_code !== want.position_code) begin
      $error("position_code: expected %h, got %h", want.position_code,
             got.position_code);
      error_count++;
    end
    if (got.velocity_code !== want.velocity_code) begin
      $error("velocity_code: expected %h, got %h", want.velocity_code,
             got.velocity_code);
      error_count++;
    end
    if (got.torque_code !== want.torque_code) begin
      $error("torque_code: expected %h, got %h", want.torque_code, got.torque_code);
      error_count++;
    end
    if (got.driver_temp !== want.driver_temp) begin
      $error("driver_temp: expected %h, got %h", want.driver_temp, got.driver_temp);
      error_count++;
    end
    if (got.winding_temp !== want.winding_temp) begin
      $error("winding_temp: expected %h, got %h", want.winding_temp,
             got.winding_temp);
      error_count++;
    end
    if (got.frame_count !== want.frame_count) begin
      $error("frame_count: expected %0d, got %0d", want.frame_count,
             got.frame_count);
      error_count++;
    end
  endfunction

  // byte driver: predicts each accepted request, then offers the next byte
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_ch.valid   <= 1'b0;
      rx_ch.rx_byte <= '0;
    end else begin
      if (rx_ch.valid && rx_ch.ready) predict_rx_byte(rx_ch.rx_byte);
      if (!rx_ch.valid || rx_ch.ready) begin
        if (pending_bytes.size() != 0 && !stall_roll()) begin
          rx_ch.valid   <= 1'b1;
          rx_ch.rx_byte <= pending_bytes.pop_front();
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  // feedback monitor: checks each decoded frame against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : fb_monitor
    result_t got;
    if (!rst_ni) begin
      fb_ch.ready <= 1'b0;
    end else begin
      if (fb_ch.valid && fb_ch.ready) begin
        got = {fb_ch.frame_id, fb_ch.payload, fb_ch.fault_code, fb_ch.node_low,
               fb_ch.position_code, fb_ch.velocity_code, fb_ch.torque_code,
               fb_ch.driver_temp, fb_ch.winding_temp, fb_ch.frame_count};
        if (expected_feedback.size() == 0) begin
          $error("unexpected feedback frame, frame_count %0d", got.frame_count);
          error_count++;
        end else begin
          check_feedback(expected_feedback.pop_front(), got);
        end
      end
      fb_ch.ready <= !stall_roll();
    end
  end

  // one complete frame with the given header bytes, content and tail
  task automatic queue_frame(input logic [15:0] hdr, input logic [31:0] id,
                             input logic [63:0] pay, input logic [7:0] tail);
    append_byte(HeadMark);
    append_byte(hdr[15:8]);
    append_byte(hdr[7:0]);
    for (int i = 0; i < 4; i++) append_byte(id[8*i +: 8]);
    for (int i = 7; i >= 0; i--) append_byte(pay[8*i +: 8]);
    append_byte(tail);
  endtask

  // line noise, weighted towards the two marker values
  task automatic queue_noise(input int unsigned n);
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15) append_byte(HeadMark);
      else if (r < 30) append_byte(TailMark);
      else append_byte(8'($urandom));
    end
  endtask

  initial begin
    int unsigned frame_bytes;
    int unsigned pick;
    int unsigned cut;
    rst_ni = 1'b0;

    // directed: field extremes
    queue_frame(16'h0000, 32'h0000_0000, 64'h0, TailMark);
    queue_frame(16'hFFFF, 32'hFFFF_FFFF, {64{1'b1}}, TailMark);
    // leading garbage ahead of a frame
    append_byte(8'h11);
    append_byte(8'h22);
    append_byte(8'h33);
    queue_frame(16'h1234, 32'h0403_0201, 64'h0123_4567_89AB_CDEF, TailMark);
    // extra start byte ahead of a frame; the window that opens at it also ends in a tail byte
    append_byte(HeadMark);
    queue_frame(16'hAA55, 32'hAA55_AA55, 64'h55AA_55AA_55AA_5555, TailMark);
    // a full window without any start byte
    for (int i = 0; i < WinLen; i++) append_byte(8'(8'h40 + i));
    // wrong tail, then a good frame
    queue_frame(16'h0F0F, 32'h8000_0001, 64'hF0E1_D2C3_B4A5_9687, 8'h54);
    queue_frame(16'hA5C3, 32'h7FFF_FFFE, 64'h8F7E_6D5C_4B3A_2910, TailMark);

    // random: mostly good frames, some broken, truncated or noisy
    frame_bytes = 0;
    while (frame_bytes < RandomBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        queue_frame(16'($urandom), $urandom, {$urandom, $urandom}, TailMark);
        frame_bytes += WinLen;
      end else if (pick < 80) begin
        queue_frame(16'($urandom), $urandom, {$urandom, $urandom},
                    8'($urandom));
        frame_bytes += WinLen;
      end else if (pick < 88) begin
        cut = $urandom_range(0, WinLen - 2);
        append_byte(HeadMark);
        for (int i = 0; i < cut; i++) append_byte(8'($urandom));
        frame_bytes += cut + 1;
      end else begin
        queue_noise($urandom_range(1, 6));
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    fork
      begin
        wait (pending_bytes.size() == 0 && !rx_ch.valid);
        wait (expected_feedback.size() == 0);
        repeat (DrainCycles) @(posedge clk_i);
      end
      wait (cycle_count >= CycleLimit);
    join_any

    if (expected_feedback.size() != 0) begin
      $error("%0d feedback frames never arrived", expected_feedback.size());
      error_count++;
    end
    if (cycle_count < CycleLimit && error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* usb_can_feedback_deframer_top.f */
rtl/udf_pkg.sv
rtl/udf_intf.sv
rtl/udf_cell.sv
rtl/udf_out_q.sv
rtl/usb_can_feedback_deframer_top.sv
tb/sv/testbench.sv
